[rtl/spectral_cos_squared_lowpass_macros.svh]
// Assertion macros for the cos-squared lowpass spectral window.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef SPECTRAL_COS_SQUARED_LOWPASS_MACROS_SVH
`define SPECTRAL_COS_SQUARED_LOWPASS_MACROS_SVH
`ifndef SYNTHESIS
`define SCSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scsl: same-cycle check failed");
`define SCSL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scsl: next-cycle check failed");
`else
`define SCSL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SCSL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/scsl_pkg.sv]
// Shared types, constants and gain-table function for the cos-squared lowpass window.
// No dependencies; imported by every module of the block.
`default_nettype none

package scsl_pkg;

  localparam int BIN_W       = 15;
  localparam int SAMPLE_W    = 32;
  localparam int PHASE_W     = 32;
  localparam int NYQ_W       = 16;
  localparam int GAIN_W      = 17;   // Q1.16 with 1.0 = 65536
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int MAX_HALF_LENGTH_DEF  = 32768;
  localparam int GAIN_TABLE_DEPTH_DEF = 1024;

  localparam logic [PHASE_W-1:0] PHASE_RESET = '0;
  localparam logic [NYQ_W-1:0]   NYQ_RESET   = 16'd512;

  localparam int unsigned ONE_Q16  = 65536;
  localparam int unsigned HALF_Q16 = 32768;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP  = 4'd0,
    REG_NYQUIST_BIN = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [BIN_W-1:0]           bin;
    logic signed [SAMPLE_W-1:0] first_word;
    logic signed [SAMPLE_W-1:0] second_word;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_out;
    logic signed [SAMPLE_W-1:0] second_out;
  } out_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [NYQ_W-1:0]   nyquist_bin;
  } cfg_t;

  typedef struct packed {
    logic                       is_dc;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] first_word;
    logic signed [SAMPLE_W-1:0] second_word;
  } gain_item_t;

  // cos^2 of a Q30 angle: Taylor series to theta^16, truncating, clamped, rounded to Q16.
  // Evaluated at elaboration only, to fill the gain ROM.
  function automatic logic [GAIN_W-1:0] gain_from_theta(input logic [63:0] theta);
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        c;
    logic [63:0]        sq;
    t2   = (theta * theta) >> 30;
    term = ONE_Q30;
    sum  = signed'(ONE_Q30);
    term = ((term * t2) >> 30) / 64'd2;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd12;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd30;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd56;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd90;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd132;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd182;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd240;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(ONE_Q30)) begin
      sum = signed'(ONE_Q30);
    end
    c  = unsigned'(sum);
    sq = c * c;
    return GAIN_W'((sq + (64'd1 << 43)) >> 44);
  endfunction

endpackage

`default_nettype wire

[rtl/scsl_cfg.sv]
// Configuration register file: phase_step and nyquist_bin behind a valid/ready write port.
// Depends on scsl_pkg.
`default_nettype none

module scsl_cfg
  import scsl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  logic [PHASE_W-1:0] phase_step;
  logic [NYQ_W-1:0]   nyquist_bin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= PHASE_RESET;
      nyquist_bin <= NYQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP:  phase_step  <= cfg_data[PHASE_W-1:0];
        REG_NYQUIST_BIN: nyquist_bin <= cfg_data[NYQ_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg.phase_step  = phase_step;
  assign cfg.nyquist_bin = nyquist_bin;

endmodule

`default_nettype wire

[rtl/scsl_gain.sv]
// Gain pipeline: bin select, r = k * phase_step, table index, registered ROM read.
// Depends on scsl_pkg and the assertion macro header.
`default_nettype none
`include "spectral_cos_squared_lowpass_macros.svh"

module scsl_gain
  import scsl_pkg::*;
#(
  parameter int MAX_HALF_LENGTH  = MAX_HALF_LENGTH_DEF,
  parameter int GAIN_TABLE_DEPTH = GAIN_TABLE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output gain_item_t out_item
);

  localparam int HL_BITS = $clog2(MAX_HALF_LENGTH + 1);
  localparam int K_W     = (HL_BITS > BIN_W) ? HL_BITS : BIN_W;
  localparam int NB_W    = (HL_BITS > NYQ_W) ? HL_BITS : NYQ_W;
  localparam int R_W     = K_W + PHASE_W;
  localparam int IDX_W   = $clog2(GAIN_TABLE_DEPTH + 1);
  localparam int P_W     = 17 + IDX_W;

  // constant gain table, read through a register
  logic [GAIN_W-1:0] gain_rom [GAIN_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= GAIN_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] THETA = (PI_Q30 * 64'(gi)) / (64'd2 * 64'(GAIN_TABLE_DEPTH));
    assign gain_rom[gi] = gain_from_theta(THETA);
  end

  logic v_g1, v_g2, v_g3, v_g4;
  logic en_g1, en_g2, en_g3, en_g4;

  logic [K_W-1:0]             g1_k;
  logic                       g1_dc, g2_dc, g3_dc, g4_dc;
  logic signed [SAMPLE_W-1:0] g1_a, g2_a, g3_a, g4_a;
  logic signed [SAMPLE_W-1:0] g1_b, g2_b, g3_b, g4_b;
  logic [R_W-1:0]             g2_r;
  logic                       g3_zero;
  logic [IDX_W-1:0]           g3_idx;
  logic [GAIN_W-1:0]          g4_gain;

  logic [NB_W-1:0]  nyq_ext;
  logic [NB_W-1:0]  nyq_eff;
  logic [K_W-1:0]   k_sel;
  logic [P_W-1:0]   idx_prod;
  logic [IDX_W:0]   idx_raw;
  logic [IDX_W-1:0] idx_clamped;

  assign en_g4    = !v_g4 || out_ready;
  assign en_g3    = !v_g3 || en_g4;
  assign en_g2    = !v_g2 || en_g3;
  assign en_g1    = !v_g1 || en_g2;
  assign in_ready = en_g1;

  // Nyquist word of bin zero uses the Nyquist bin; zero or oversize means the maximum
  always_comb begin
    nyq_ext = NB_W'(cfg.nyquist_bin);
    if (nyq_ext == '0 || nyq_ext > NB_W'(MAX_HALF_LENGTH)) begin
      nyq_eff = NB_W'(MAX_HALF_LENGTH);
    end else begin
      nyq_eff = nyq_ext;
    end
    k_sel = (in_item.bin == '0) ? K_W'(nyq_eff) : K_W'(in_item.bin);
  end

  always_comb begin
    idx_prod = P_W'(g2_r[16:0]) * P_W'(GAIN_TABLE_DEPTH) + P_W'(HALF_Q16);
    idx_raw  = idx_prod[P_W-1:16];
    if (idx_raw > (IDX_W+1)'(GAIN_TABLE_DEPTH)) begin
      idx_clamped = IDX_W'(GAIN_TABLE_DEPTH);
    end else begin
      idx_clamped = idx_raw[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_g1 <= 1'b0;
      v_g2 <= 1'b0;
      v_g3 <= 1'b0;
      v_g4 <= 1'b0;
    end else begin
      if (en_g1) v_g1 <= in_valid;
      if (en_g2) v_g2 <= v_g1;
      if (en_g3) v_g3 <= v_g2;
      if (en_g4) v_g4 <= v_g3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_g1) begin
      g1_k  <= k_sel;
      g1_dc <= (in_item.bin == '0);
      g1_a  <= in_item.first_word;
      g1_b  <= in_item.second_word;
    end
    if (en_g2) begin
      g2_r  <= R_W'(g1_k) * R_W'(cfg.phase_step);
      g2_dc <= g1_dc;
      g2_a  <= g1_a;
      g2_b  <= g1_b;
    end
    if (en_g3) begin
      g3_zero <= (g2_r > R_W'(ONE_Q16));
      g3_idx  <= idx_clamped;
      g3_dc   <= g2_dc;
      g3_a    <= g2_a;
      g3_b    <= g2_b;
    end
    if (en_g4) begin
      g4_gain <= g3_zero ? '0 : gain_rom[g3_idx];
      g4_dc   <= g3_dc;
      g4_a    <= g3_a;
      g4_b    <= g3_b;
    end
  end

  assign out_valid            = v_g4;
  assign out_item.is_dc       = g4_dc;
  assign out_item.gain        = g4_gain;
  assign out_item.first_word  = g4_a;
  assign out_item.second_word = g4_b;

  `SCSL_ASSERT_IMP(a_idx_in_range, clk, rst, v_g3, g3_idx <= IDX_W'(GAIN_TABLE_DEPTH))
  `SCSL_ASSERT_NXT(a_cutoff_zero_gain, clk, rst, v_g3 && g3_zero && en_g4, g4_gain == '0)
  `SCSL_ASSERT_NXT(a_stall_holds_gain, clk, rst, v_g4 && !out_ready, v_g4 && $stable(g4_gain))

endmodule

`default_nettype wire

[rtl/scsl_scale.sv]
// Scaling pipeline: magnitude, rounded Q16 product, sign restore and DC bypass.
// Depends on scsl_pkg.
`default_nettype none

module scsl_scale
  import scsl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire gain_item_t in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_item
);

  localparam int PR_W = SAMPLE_W + GAIN_W;

  logic v_s1, v_s2, v_s3;
  logic en_s1, en_s2, en_s3;

  logic [SAMPLE_W-1:0] a_u, b_u;
  logic [SAMPLE_W-1:0] mag_a, mag_b;

  logic                s1_dc, s2_dc;
  logic                s1_neg_a, s1_neg_b, s2_neg_a, s2_neg_b;
  logic [SAMPLE_W-1:0] s1_mag_a, s1_mag_b;
  logic [SAMPLE_W-1:0] s1_raw_a, s2_raw_a;
  logic [GAIN_W-1:0]   s1_gain;
  logic [PR_W-1:0]     s2_prod_a, s2_prod_b;

  logic [SAMPLE_W-1:0] res_a, res_b;
  logic [SAMPLE_W-1:0] first_next, second_next;
  logic [SAMPLE_W-1:0] first_q, second_q;

  assign en_s3    = !v_s3 || out_ready;
  assign en_s2    = !v_s2 || en_s3;
  assign en_s1    = !v_s1 || en_s2;
  assign in_ready = en_s1;

  // magnitude of the most negative value is 2^(W-1), which fits unsigned
  always_comb begin
    a_u   = in_item.first_word;
    b_u   = in_item.second_word;
    mag_a = a_u[SAMPLE_W-1] ? (~a_u + SAMPLE_W'(1)) : a_u;
    mag_b = b_u[SAMPLE_W-1] ? (~b_u + SAMPLE_W'(1)) : b_u;
  end

  // rounded result never exceeds the magnitude, so W bits hold it
  always_comb begin
    res_a       = s2_prod_a[16 +: SAMPLE_W];
    res_b       = s2_prod_b[16 +: SAMPLE_W];
    second_next = s2_neg_b ? (~res_b + SAMPLE_W'(1)) : res_b;
    if (s2_dc) begin
      first_next = s2_raw_a;
    end else begin
      first_next = s2_neg_a ? (~res_a + SAMPLE_W'(1)) : res_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
      v_s2 <= 1'b0;
      v_s3 <= 1'b0;
    end else begin
      if (en_s1) v_s1 <= in_valid;
      if (en_s2) v_s2 <= v_s1;
      if (en_s3) v_s3 <= v_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_dc    <= in_item.is_dc;
      s1_neg_a <= a_u[SAMPLE_W-1];
      s1_neg_b <= b_u[SAMPLE_W-1];
      s1_mag_a <= mag_a;
      s1_mag_b <= mag_b;
      s1_raw_a <= a_u;
      s1_gain  <= in_item.gain;
    end
    if (en_s2) begin
      s2_prod_a <= PR_W'(s1_mag_a) * PR_W'(s1_gain) + PR_W'(HALF_Q16);
      s2_prod_b <= PR_W'(s1_mag_b) * PR_W'(s1_gain) + PR_W'(HALF_Q16);
      s2_neg_a  <= s1_neg_a;
      s2_neg_b  <= s1_neg_b;
      s2_dc     <= s1_dc;
      s2_raw_a  <= s1_raw_a;
    end
    if (en_s3) begin
      first_q  <= first_next;
      second_q <= second_next;
    end
  end

  assign out_valid           = v_s3;
  assign out_item.first_out  = first_q;
  assign out_item.second_out = second_q;

endmodule

`default_nettype wire

[rtl/spectral_cos_squared_lowpass.sv]
// Cos-squared lowpass gain on a packed real-FFT spectrum, one bin per request.
// Pipeline: 4 gain stages, then 3 scale stages, from input accept to output valid.
// Throughput: one request per cycle while out_ready holds; each stage advances when the next one is empty
// or moving, so a stalled output only backs up as far as the pipeline is full.
// Reset (synchronous, active high) clears all stage valid bits, sets phase_step to 0
// and nyquist_bin to 512; the gain table is a constant ROM and needs no fill pass.
`default_nettype none

module spectral_cos_squared_lowpass
  import scsl_pkg::*;
#(
  parameter int MAX_HALF_LENGTH  = MAX_HALF_LENGTH_DEF,
  parameter int GAIN_TABLE_DEPTH = GAIN_TABLE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_t                        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  gain_item_t gain_item;
  logic       gain_valid;
  logic       gain_ready;

  scsl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scsl_gain #(
    .MAX_HALF_LENGTH  (MAX_HALF_LENGTH),
    .GAIN_TABLE_DEPTH (GAIN_TABLE_DEPTH)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_data),
    .out_valid (gain_valid),
    .out_ready (gain_ready),
    .out_item  (gain_item)
  );

  scsl_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gain_valid),
    .in_ready  (gain_ready),
    .in_item   (gain_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking bench for spectral_cos_squared_lowpass: streams spectrum bins through
// the window with random idling, predicts every result, compares field by field.
// Depends on scsl_pkg (rtl/scsl_pkg.sv) and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import scsl_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_PRINTS   = 40;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_e;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    out_t             res;
  } scaled_bin_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic [GAIN_W-1:0]  gain_rom [0:GAIN_TABLE_DEPTH_DEF];
  logic [PHASE_W-1:0] phase_step_q  = PHASE_RESET;
  logic [NYQ_W-1:0]   nyquist_bin_q = NYQ_RESET;

  in_t         pending_bins[$];
  scaled_bin_t expected_spectrum[$];
  bit          in_accepted    = 1'b0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          error_count    = 0;
  int          cycle_count    = 0;

  spectral_cos_squared_lowpass u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cos^2 table entry: Q30 Taylor series, truncating, clamped, squared, rounded to Q16
  function automatic logic [GAIN_W-1:0] cos_sq_entry(int unsigned i);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        c;
    logic signed [63:0] acc;
    theta = (PI_Q30 * 64'(i)) / 64'(2 * GAIN_TABLE_DEPTH_DEF);
    t2    = (theta * theta) >> 30;
    term  = ONE_Q30;
    acc   = signed'(ONE_Q30);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * t2) >> 30) / (64'(2 * k - 1) * 64'(2 * k));
      if (k % 2 == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > signed'(ONE_Q30)) begin
      acc = signed'(ONE_Q30);
    end
    c = unsigned'(acc);
    return GAIN_W'((c * c + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic [GAIN_W-1:0] gain_of_bin(logic [63:0] k);
    logic [63:0] r;
    logic [63:0] idx;
    r = k * 64'(phase_step_q);
    if (r > 64'(ONE_Q16)) begin
      return '0;
    end
    idx = (r * 64'(GAIN_TABLE_DEPTH_DEF) + 64'(HALF_Q16)) >> 16;
    if (idx > 64'(GAIN_TABLE_DEPTH_DEF)) begin
      idx = 64'(GAIN_TABLE_DEPTH_DEF);
    end
    return gain_rom[idx];
  endfunction

  // magnitude scaled and rounded, sign put back: rounds half away from zero
  function automatic logic [SAMPLE_W-1:0] scale_word(logic [SAMPLE_W-1:0] x,
                                                     logic [GAIN_W-1:0] g);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = {32'd0, x[SAMPLE_W-1] ? (~x + 1'b1) : x};
    prod = (mag * 64'(g) + 64'(HALF_Q16)) >> 16;
    return x[SAMPLE_W-1] ? (~prod[SAMPLE_W-1:0] + 1'b1) : prod[SAMPLE_W-1:0];
  endfunction

  function automatic out_t lowpass_predict(in_t req);
    out_t              res;
    logic [63:0]       nb;
    logic [GAIN_W-1:0] g;
    if (req.bin == '0) begin
      nb = 64'(nyquist_bin_q);
      if (nb == 0 || nb > 64'(MAX_HALF_LENGTH_DEF)) begin
        nb = 64'(MAX_HALF_LENGTH_DEF);
      end
      res.first_out  = req.first_word;
      res.second_out = scale_word(req.second_word, gain_of_bin(nb));
    end else begin
      g              = gain_of_bin(64'(req.bin));
      res.first_out  = scale_word(req.first_word, g);
      res.second_out = scale_word(req.second_word, g);
    end
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // Driver: new request only when the channel is empty or the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      if (!in_valid || in_accepted) begin
        if (pending_bins.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_data  <= pending_bins.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: tracks register writes, predicts accepted requests, checks results
  always @(posedge clk) begin
    scaled_bin_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      in_accepted = 1'b0;
      if (!rst) begin
        if (cfg_valid && cfg_ready) begin
          case (cfg_index)
            REG_PHASE_STEP:  phase_step_q  = cfg_data;
            REG_NYQUIST_BIN: nyquist_bin_q = cfg_data[NYQ_W-1:0];
            default: ;
          endcase
        end
        if (in_valid && in_ready) begin
          want.bin = in_data.bin;
          want.res = lowpass_predict(in_data);
          expected_spectrum.push_back(want);
          in_accepted = 1'b1;
        end
        if (out_valid && out_ready) begin
          if (expected_spectrum.size() == 0) begin
            note_mismatch($sformatf("unexpected result %h", out_data));
          end else begin
            want = expected_spectrum.pop_front();
            if (out_data.first_out !== want.res.first_out) begin
              note_mismatch($sformatf("bin %0d first_out got %0d want %0d", want.bin,
                                      out_data.first_out, want.res.first_out));
            end
            if (out_data.second_out !== want.res.second_out) begin
              note_mismatch($sformatf("bin %0d second_out got %0d want %0d", want.bin,
                                      out_data.second_out, want.res.second_out));
            end
          end
        end
      end
    end
  end

  function automatic void queue_bin(int unsigned bin, logic [31:0] a, logic [31:0] b);
    in_t req;
    req.bin         = BIN_W'(bin);
    req.first_word  = a;
    req.second_word = b;
    pending_bins.push_back(req);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(0, 4));
      default: return $urandom;
    endcase
  endfunction

  // Most bins fall below the cutoff so the gain curve gets exercised
  function automatic in_t random_bin_item(logic [31:0] ps);
    in_t             req;
    longint unsigned reach;
    int unsigned     pick;
    reach = (ps == 0) ? 32767 : 65536 / longint'(ps) + 2;
    if (reach > 32767) begin
      reach = 32767;
    end
    pick = $urandom_range(0, 15);
    if (pick < 2) begin
      req.bin = '0;
    end else if (pick < 4) begin
      req.bin = BIN_W'($urandom);
    end else begin
      req.bin = BIN_W'($urandom_range(1, int'(reach)));
    end
    req.first_word  = random_word();
    req.second_word = random_word();
    return req;
  endfunction

  function automatic logic [31:0] random_phase_step();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'($urandom_range(1, 64));
      default: return 32'($urandom_range(16, 4096));
    endcase
  endfunction

  function automatic logic [31:0] random_nyquist();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 1024));
      2:       return 32'($urandom_range(32760, 32776));
      default: return 32'($urandom_range(1, 40000));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_bins.size() != 0 || in_valid || expected_spectrum.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic start_phase(flow_mode_e mode);
    wait_drained();
    src_idle_pct   = (mode == FLOW_SRC_IDLE) ? 80 : (mode == FLOW_BOTH) ? 31 : 0;
    sink_stall_pct = (mode == FLOW_SINK_STALL) ? 80 : (mode == FLOW_BOTH) ? 31 : 0;
  endtask

  // Back-to-back writes keep cfg_valid high; close_writes lowers it once
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] ps;
    for (int i = 0; i <= GAIN_TABLE_DEPTH_DEF; i++) begin
      gain_rom[i] = cos_sq_entry(i);
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: unity gain everywhere
    start_phase(FLOW_FREE);
    queue_bin(0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_bin(0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_bin(1, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_bin(32767, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_bin(16384, 32'h0000_0000, 32'h5555_AAAA);

    // bin 1 lands on half gain: rounding away from zero; Nyquist bin 1
    start_phase(FLOW_SRC_IDLE);
    write_reg(REG_PHASE_STEP, 32'd32768);
    write_reg(REG_NYQUIST_BIN, 32'd1);
    close_writes();
    queue_bin(1, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_bin(1, 32'h0000_0003, 32'hFFFF_FFFD);
    queue_bin(2, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_bin(3, 32'h0000_3039, 32'hFFFF_CFC7);
    queue_bin(0, 32'hFFFF_FFFB, 32'h8000_0000);

    // cutoff exactly at bin 1; Nyquist written as zero (upper data bits set)
    start_phase(FLOW_SINK_STALL);
    write_reg(REG_PHASE_STEP, 32'd65536);
    write_reg(REG_NYQUIST_BIN, 32'h0001_0000);
    close_writes();
    queue_bin(1, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_bin(2, 32'd1000, 32'd1000);
    queue_bin(0, 32'd42, 32'h7FFF_FFFF);

    // largest step, oversized Nyquist, writes to unmapped indexes
    start_phase(FLOW_BOTH);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_NYQUIST_BIN, 32'hA5A5_FFFF);
    write_reg(REG_SPARE_LO, 32'h0000_0000);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    close_writes();
    queue_bin(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_bin(32767, 32'h8000_0000, 32'h1234_5678);
    queue_bin(0, 32'h8000_0000, 32'h7FFF_FFFF);

    // Nyquist at the top of its range sits exactly on the cutoff
    start_phase(FLOW_FREE);
    write_reg(REG_PHASE_STEP, 32'd2);
    write_reg(REG_NYQUIST_BIN, 32'd32768);
    close_writes();
    queue_bin(32767, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_bin(16384, 32'h4000_0000, 32'hC000_0000);
    queue_bin(0, 32'h0000_0001, 32'h7FFF_FFFF);
    queue_bin(1, 32'h7FFF_FFFF, 32'h8000_0000);

    for (int p = 0; p < 8; p++) begin
      start_phase(flow_mode_e'(p % 4));
      ps = (p == 0) ? 32'd1 : random_phase_step();
      write_reg(REG_PHASE_STEP, ps);
      write_reg(REG_NYQUIST_BIN, random_nyquist());
      close_writes();
      for (int n = 0; n < 50; n++) begin
        pending_bins.push_back(random_bin_item(ps));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_spectrum.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", expected_spectrum.size()));
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
